@@ rtl/vertex_dedup_table_core_defines.svh @@
// assertion macros shared by the vertex dedup table checker
`ifndef VERTEX_DEDUP_TABLE_CORE_DEFINES_SVH
`define VERTEX_DEDUP_TABLE_CORE_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define VDT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("vertex dedup table check failed");

// next-cycle implication, disabled while in reset
`define VDT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("vertex dedup table check failed");

`endif

@@ rtl/vdt_pkg.sv @@
// types, constants and compare functions of the vertex dedup table
`timescale 1ns / 1ps
`default_nettype none
package vdt_pkg;

	localparam int TABLE_DEPTH = 1024;
	localparam int WORDS_PER_VERTEX = 8;
	localparam int IDX_W = $clog2(TABLE_DEPTH);
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
	localparam int OUT_IDX_W = 10;

	localparam logic CMD_LOOKUP = 1'b0;
	localparam logic CMD_CLEAR = 1'b1;

	typedef logic [WORDS_PER_VERTEX-1:0][31:0] vertex_t;

	typedef struct packed {
		logic        command;
		logic [31:0] pos_x;
		logic [31:0] pos_y;
		logic [31:0] pos_z;
		logic [31:0] norm_x;
		logic [31:0] norm_y;
		logic [31:0] norm_z;
		logic [31:0] tex_s;
		logic [31:0] tex_t;
	} req_t;

	typedef struct packed {
		logic [OUT_IDX_W-1:0] vertex_index;
		logic                 was_inserted;
		logic                 table_full;
	} rsp_t;

	typedef enum logic [2:0] {
		ST_IDLE    = 3'b001,
		ST_SEARCH  = 3'b010,
		ST_DELIVER = 3'b100
	} state_t;

	typedef struct packed {
		logic start;
		logic clear;
		logic read;
		logic decide;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic more;
		logic pending;
		logic hit;
		logic out_free;
	} status_t;

	function automatic logic word_is_nan(logic [31:0] w);
		return (w[30:23] == 8'hFF) && (w[22:0] != 23'd0);
	endfunction

	// ieee equality: nan never equal, +0 equals -0
	function automatic logic words_equal(logic [31:0] a, logic [31:0] b);
		logic both_zero;
		both_zero = ((a[30:0] | b[30:0]) == 31'd0);
		return !word_is_nan(a) && !word_is_nan(b) && ((a == b) || both_zero);
	endfunction

	function automatic logic entry_match(vertex_t stored, vertex_t probe);
		logic m;
		m = 1'b1;
		for (int k = 0; k < WORDS_PER_VERTEX; k++) begin
			m = m & words_equal(stored[k], probe[k]);
		end
		return m;
	endfunction

	function automatic vertex_t req_vertex(req_t r);
		vertex_t v;
		v[0] = r.pos_x;
		v[1] = r.pos_y;
		v[2] = r.pos_z;
		v[3] = r.norm_x;
		v[4] = r.norm_y;
		v[5] = r.norm_z;
		v[6] = r.tex_s;
		v[7] = r.tex_t;
		return v;
	endfunction

endpackage
`default_nettype wire

@@ rtl/vertex_dedup_table_core.sv @@
// Vertex de-duplication table: each lookup request scans the stored vertices in insertion
// order, one entry per cycle through the single read port of the vertex store, and returns
// the index of the first IEEE-equal entry, or appends the vertex, or reports a full table.
// A lookup steps through the accepting cycle, one read per entry, the compare of the last
// read, the decision and the load of the output register; a hit ends the scan early, and a
// response still stalled in the output register holds the lookup until it is taken. A clear
// request gives no response and leaves the block idle. The store is not cleared after reset,
// only entries below the count are ever read, so the block is ready right out of reset. A
// finished response waits in the output register while the next request is taken.
`timescale 1ns / 1ps
`default_nettype none
module vertex_dedup_table_core (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_stall,
	input  wire vdt_pkg::req_t req_data,
	output logic               rsp_valid,
	input  wire logic          rsp_stall,
	output vdt_pkg::rsp_t      rsp_data
);

	vdt_pkg::cmd_t    cmd;
	vdt_pkg::status_t st;

	vdt_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_command (req_data.command),
		.req_stall   (req_stall),
		.st          (st),
		.cmd         (cmd)
	);

	vdt_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_data  (req_data),
		.cmd       (cmd),
		.st        (st),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_data  (rsp_data)
	);

endmodule
`default_nettype wire

@@ rtl/vdt_ctrl.sv @@
// controller state machine: sequences the search, the decision and the delivery
`timescale 1ns / 1ps
`default_nettype none
module vdt_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             req_valid,
	input  wire logic             req_command,
	output logic                  req_stall,
	input  wire vdt_pkg::status_t st,
	output vdt_pkg::cmd_t         cmd
);

	vdt_pkg::state_t state_q;
	vdt_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= vdt_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign req_stall = (state_q != vdt_pkg::ST_IDLE);

	always_comb begin
		state_d = state_q;
		cmd = '0;
		case (state_q)
			vdt_pkg::ST_IDLE: begin
				if (req_valid) begin
					if (req_command == vdt_pkg::CMD_CLEAR) begin
						cmd.clear = 1'b1;
					end else begin
						cmd.start = 1'b1;
						state_d = vdt_pkg::ST_SEARCH;
					end
				end
			end
			vdt_pkg::ST_SEARCH: begin
				cmd.read = st.more && !st.hit;
				// done on the first hit, or once every stored entry was compared
				if (st.hit || (!st.more && !st.pending)) begin
					cmd.decide = 1'b1;
					state_d = vdt_pkg::ST_DELIVER;
				end
			end
			vdt_pkg::ST_DELIVER: begin
				if (st.out_free) begin
					cmd.load_out = 1'b1;
					state_d = vdt_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = vdt_pkg::ST_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire

@@ rtl/vdt_datapath.sv @@
// datapath: vertex store, scan pointer, compare stage, entry count and output register
`timescale 1ns / 1ps
`default_nettype none
module vdt_datapath (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire vdt_pkg::req_t req_data,
	input  wire vdt_pkg::cmd_t cmd,
	output vdt_pkg::status_t   st,
	output logic               rsp_valid,
	input  wire logic          rsp_stall,
	output vdt_pkg::rsp_t      rsp_data
);

	vdt_pkg::vertex_t mem [vdt_pkg::TABLE_DEPTH];

	vdt_pkg::vertex_t               probe_q;
	vdt_pkg::vertex_t               rd_data_s1;
	logic [vdt_pkg::CNT_W-1:0]      addr_q;
	logic [vdt_pkg::CNT_W-1:0]      count_q;
	logic                           cmp_vld_s1;
	logic [vdt_pkg::IDX_W-1:0]      cmp_idx_s1;
	vdt_pkg::rsp_t                  res_q;
	logic                           out_valid_q;
	vdt_pkg::rsp_t                  out_q;

	logic                           hit;
	logic                           full;
	logic                           insert;
	logic [vdt_pkg::IDX_W-1:0]      res_idx;
	logic [vdt_pkg::IDX_W+vdt_pkg::OUT_IDX_W-1:0] res_idx_ext;

	assign hit    = cmp_vld_s1 && vdt_pkg::entry_match(rd_data_s1, probe_q);
	assign full   = (count_q == vdt_pkg::CNT_W'(vdt_pkg::TABLE_DEPTH));
	assign insert = cmd.decide && !hit && !full;

	// hit index or the append slot; a miss on a full table reports index zero
	always_comb begin
		if (hit) begin
			res_idx = cmp_idx_s1;
		end else if (full) begin
			res_idx = '0;
		end else begin
			res_idx = count_q[vdt_pkg::IDX_W-1:0];
		end
	end
	assign res_idx_ext = {{vdt_pkg::OUT_IDX_W{1'b0}}, res_idx};

	assign st.more     = (addr_q < count_q);
	assign st.pending  = cmp_vld_s1;
	assign st.hit      = hit;
	assign st.out_free = !out_valid_q || !rsp_stall;

	// store: one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (insert) begin
			mem[count_q[vdt_pkg::IDX_W-1:0]] <= probe_q;
		end
		if (cmd.read) begin
			rd_data_s1 <= mem[addr_q[vdt_pkg::IDX_W-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			probe_q <= vdt_pkg::req_vertex(req_data);
		end
		if (cmd.read) begin
			cmp_idx_s1 <= addr_q[vdt_pkg::IDX_W-1:0];
		end
		if (cmd.decide) begin
			res_q.vertex_index <= res_idx_ext[vdt_pkg::OUT_IDX_W-1:0];
			res_q.was_inserted <= !hit && !full;
			res_q.table_full   <= !hit && full;
		end
		if (cmd.load_out) begin
			out_q <= res_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q      <= '0;
			count_q     <= '0;
			cmp_vld_s1  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.start) begin
				addr_q <= '0;
			end else if (cmd.read) begin
				addr_q <= addr_q + 1'b1;
			end
			cmp_vld_s1 <= cmd.read && !cmd.start;
			if (cmd.clear) begin
				count_q <= '0;
			end else if (insert) begin
				count_q <= count_q + 1'b1;
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp_data  = out_q;

endmodule
`default_nettype wire

@@ rtl/vdt_checker.sv @@
// port-level checker for the vertex dedup table and its bind
`timescale 1ns / 1ps
`default_nettype none
`include "vertex_dedup_table_core_defines.svh"
module vdt_checker (
	input wire logic          clk,
	input wire logic          arst_n,
	input wire logic          req_valid,
	input wire logic          req_stall,
	input wire vdt_pkg::req_t req_data,
	input wire logic          rsp_valid,
	input wire logic          rsp_stall,
	input wire vdt_pkg::rsp_t rsp_data
);

	logic lookup_acc;
	logic clear_acc;
	logic both_flags;
	logic rsp_full;

	assign lookup_acc = req_valid && !req_stall && (req_data.command == vdt_pkg::CMD_LOOKUP);
	assign clear_acc  = req_valid && !req_stall && (req_data.command == vdt_pkg::CMD_CLEAR);
	assign both_flags = rsp_data.was_inserted && rsp_data.table_full;
	assign rsp_full   = rsp_valid && rsp_data.table_full;

	// a stalled response holds
	`VDT_ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data))

	// inserted and full never together
	`VDT_ASSERT_NOW(a_flags_excl, clk, arst_n, rsp_valid, !both_flags)

	// a full response reports index zero
	`VDT_ASSERT_NOW(a_full_idx, clk, arst_n, rsp_full, rsp_data.vertex_index == '0)

	// a lookup request busies the block for the search
	`VDT_ASSERT_NEXT(a_lookup_busy, clk, arst_n, lookup_acc, req_stall)

	// a clear request leaves the block ready
	`VDT_ASSERT_NEXT(a_clear_ready, clk, arst_n, clear_acc, !req_stall)

endmodule

bind vertex_dedup_table_core vdt_checker u_vdt_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_stall (req_stall),
	.req_data  (req_data),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp_data  (rsp_data)
);
`default_nettype wire

@@ bench/vertex_dedup_table_core_tb.sv @@
// self-checking testbench for the vertex dedup table core
`timescale 1ns / 1ps
module vertex_dedup_table_core_tb;

	localparam logic [31:0] POS_ZERO   = 32'h0000_0000;
	localparam logic [31:0] NEG_ZERO   = 32'h8000_0000;
	localparam logic [31:0] FP_ONE     = 32'h3f80_0000;
	localparam logic [31:0] FP_NEG_TWO = 32'hc000_0000;
	localparam logic [31:0] POS_INF    = 32'h7f80_0000;
	localparam logic [31:0] NEG_INF    = 32'hff80_0000;
	localparam logic [31:0] MAX_FINITE = 32'h7f7f_ffff;
	localparam logic [31:0] QUIET_NAN  = 32'h7fc0_0000;
	localparam logic [31:0] ALL_ONES   = 32'hffff_ffff;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int DRAIN_CYCLES   = vdt_pkg::TABLE_DEPTH + 64;
	localparam int RANDOM_ITEMS   = 580;
	localparam int MAX_REPORTS    = 10;

	logic           clk = 1'b0;
	logic           arst_n;
	logic           req_valid;
	logic           req_stall;
	vdt_pkg::req_t  req_data;
	logic           rsp_valid;
	logic           rsp_stall;
	vdt_pkg::rsp_t  rsp_data;

	// software copy of the table
	logic [255:0]   mesh_store [vdt_pkg::TABLE_DEPTH];
	int unsigned    mesh_count = 0;
	vdt_pkg::rsp_t  pending_indexes [$];

	int  error_count = 0;
	int  quiet_cycles = 0;
	bit  idle_on = 1'b1;

	vertex_dedup_table_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_data  (req_data),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_data  (rsp_data)
	);

	always #10 clk = ~clk;

	function automatic bit is_nan_bits(logic [31:0] w);
		return (w & 32'h7fff_ffff) > 32'h7f80_0000;
	endfunction

	function automatic bit float_same(logic [31:0] a, logic [31:0] b);
		if (is_nan_bits(a) || is_nan_bits(b))
			return 1'b0;
		return (a == b) || (((a | b) & 32'h7fff_ffff) == 32'd0);
	endfunction

	function automatic bit vertex_same(logic [255:0] a, logic [255:0] b);
		for (int k = 0; k < 8; k++) begin
			if (!float_same(a[32*k +: 32], b[32*k +: 32]))
				return 1'b0;
		end
		return 1'b1;
	endfunction

	function automatic logic [255:0] pack_vertex(vdt_pkg::req_t r);
		return {r.pos_x, r.pos_y, r.pos_z, r.norm_x, r.norm_y, r.norm_z, r.tex_s, r.tex_t};
	endfunction

	function automatic vdt_pkg::req_t unpack_vertex(logic [255:0] v);
		return vdt_pkg::req_t'({vdt_pkg::CMD_LOOKUP, v});
	endfunction

	// appends one expected response to the queue
	function automatic void add_expected(vdt_pkg::rsp_t want);
		pending_indexes = {pending_indexes, want};
	endfunction

	// works out the index the table should return and queues it
	function automatic void lookup_index(vdt_pkg::req_t r);
		logic [255:0] probe;
		vdt_pkg::rsp_t want;
		probe = pack_vertex(r);
		want = '0;
		if (r.command == vdt_pkg::CMD_CLEAR) begin
			mesh_count = 0;
			return;
		end
		for (int unsigned i = 0; i < mesh_count; i++) begin
			if (vertex_same(mesh_store[i], probe)) begin
				want.vertex_index = i[vdt_pkg::OUT_IDX_W-1:0];
				add_expected(want);
				return;
			end
		end
		if (mesh_count >= vdt_pkg::TABLE_DEPTH) begin
			want.table_full = 1'b1;
		end else begin
			mesh_store[mesh_count] = probe;
			want.vertex_index = mesh_count[vdt_pkg::OUT_IDX_W-1:0];
			want.was_inserted = 1'b1;
			mesh_count++;
		end
		add_expected(want);
	endfunction

	task automatic send_request(input vdt_pkg::req_t r);
		int gap;
		gap = idle_on ? $urandom_range(0, 4) : 0;
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req_data <= r;
		do @(posedge clk); while (req_stall);
		lookup_index(r);
	endtask

	function automatic logic [31:0] pick_word();
		logic [31:0] w;
		w = $urandom();
		case ($urandom_range(0, 9))
			0: w = POS_ZERO;
			1: w = NEG_ZERO;
			2: w = FP_ONE;
			3: w = FP_NEG_TWO;
			4: w = $urandom_range(0, 1) ? POS_INF : NEG_INF;
			5: begin
				// nan with random sign and payload
				w[30:23] = 8'hff;
				if (w[22:0] == 23'd0)
					w[0] = 1'b1;
			end
			default: ;
		endcase
		return w;
	endfunction

	function automatic logic [255:0] flip_zero_signs(logic [255:0] v);
		for (int k = 0; k < 8; k++) begin
			if (v[32*k +: 31] == 31'd0 && $urandom_range(0, 1))
				v[32*k + 31] = ~v[32*k + 31];
		end
		return v;
	endfunction

	function automatic logic [255:0] random_vertex();
		logic [255:0] v;
		for (int k = 0; k < 8; k++)
			v[32*k +: 32] = pick_word();
		return v;
	endfunction

	function automatic vdt_pkg::req_t clear_request();
		vdt_pkg::req_t r;
		r = unpack_vertex({$urandom(), $urandom(), $urandom(), $urandom(),
			$urandom(), $urandom(), $urandom(), $urandom()});
		r.command = vdt_pkg::CMD_CLEAR;
		return r;
	endfunction

	function automatic vdt_pkg::req_t random_request();
		logic [255:0] v;
		int unsigned roll;
		int unsigned slot;
		roll = $urandom_range(0, 99);
		if (roll < 4)
			return clear_request();
		if (mesh_count > 0 && roll < 65) begin
			slot = $urandom_range(0, mesh_count - 1);
			v = flip_zero_signs(mesh_store[slot]);
			// near miss: one word replaced
			if (roll >= 50)
				v[32*$urandom_range(0, 7) +: 32] = pick_word();
			return unpack_vertex(v);
		end
		return unpack_vertex(random_vertex());
	endfunction

	function automatic void flag_error(string what, vdt_pkg::rsp_t want, vdt_pkg::rsp_t got);
		error_count++;
		if (error_count <= MAX_REPORTS)
			$display("mismatch %s: expected index %0d ins %0b full %0b, ",
				what, want.vertex_index, want.was_inserted, want.table_full,
				"got index %0d ins %0b full %0b",
				got.vertex_index, got.was_inserted, got.table_full);
	endfunction

	// response checker
	always @(posedge clk) begin
		vdt_pkg::rsp_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (pending_indexes.size() == 0) begin
				flag_error("unexpected response", '0, rsp_data);
			end else begin
				want = pending_indexes.pop_front();
				if (rsp_data.vertex_index !== want.vertex_index)
					flag_error("vertex_index", want, rsp_data);
				else if (rsp_data.was_inserted !== want.was_inserted)
					flag_error("was_inserted", want, rsp_data);
				else if (rsp_data.table_full !== want.table_full)
					flag_error("table_full", want, rsp_data);
			end
		end
	end

	// response side back-pressure
	initial begin
		int hold;
		rsp_stall = 1'b1;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			hold = idle_on ? $urandom_range(0, 4) : 0;
			if (hold > 0) begin
				rsp_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			rsp_stall <= 1'b0;
			do @(posedge clk); while (!(rsp_valid && !rsp_stall));
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("vertex_dedup_table_core_tb failed");
				$finish;
			end
		end
	end

	task automatic test_lookup_basics();
		logic [255:0] base;
		logic [255:0] v;
		base = {FP_ONE, POS_ZERO, NEG_ZERO, FP_NEG_TWO, MAX_FINITE, POS_ZERO, 32'h0000_0001,
			32'h8000_0001};
		send_request(unpack_vertex(base));
		send_request(unpack_vertex(base));
		// +0 and -0 swapped must still hit
		send_request(unpack_vertex(base ^ {32'd0, NEG_ZERO, NEG_ZERO, 32'd0, 32'd0,
			NEG_ZERO, 32'd0, 32'd0}));
		send_request(unpack_vertex({8{POS_ZERO}}));
		send_request(unpack_vertex({8{NEG_ZERO}}));
		v = {POS_INF, NEG_INF, POS_INF, NEG_INF, MAX_FINITE, 32'hff7f_ffff, FP_ONE, FP_ONE};
		send_request(unpack_vertex(v));
		send_request(unpack_vertex(v));
		// a nan never matches, so it is appended each time
		v = {FP_ONE, FP_ONE, FP_ONE, QUIET_NAN, FP_ONE, FP_ONE, FP_ONE, FP_ONE};
		send_request(unpack_vertex(v));
		send_request(unpack_vertex(v));
		send_request(unpack_vertex({8{ALL_ONES}}));
		send_request(unpack_vertex({8{32'h7fff_ffff}}));
		for (int k = 0; k < 8; k++) begin
			v = base;
			v[32*k +: 32] = v[32*k +: 32] ^ 32'h0040_0000;
			send_request(unpack_vertex(v));
		end
		send_request(clear_request());
		send_request(unpack_vertex(base));
		send_request(unpack_vertex(base));
		send_request(vdt_pkg::req_t'({vdt_pkg::CMD_CLEAR, {8{ALL_ONES}}}));
		send_request(unpack_vertex({8{NEG_ZERO}}));
	endtask

	task automatic test_full_table();
		logic [255:0] v;
		send_request(clear_request());
		for (int i = 0; i < vdt_pkg::TABLE_DEPTH; i++) begin
			for (int k = 0; k < 7; k++)
				v[32*k +: 32] = $urandom() & 32'hbfff_ffff;
			v[255:224] = FP_ONE + i;
			send_request(unpack_vertex(v));
		end
		send_request(unpack_vertex({FP_NEG_TWO, 224'd0}));
		send_request(unpack_vertex(mesh_store[vdt_pkg::TABLE_DEPTH-1]));
		send_request(unpack_vertex(flip_zero_signs(mesh_store[0])));
		send_request(unpack_vertex({QUIET_NAN, mesh_store[5][223:0]}));
		send_request(unpack_vertex(mesh_store[$urandom_range(1, vdt_pkg::TABLE_DEPTH - 2)]));
		send_request(unpack_vertex(random_vertex()));
		send_request(clear_request());
		send_request(unpack_vertex({FP_NEG_TWO, 224'd0}));
	endtask

	task automatic test_random_meshes();
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			// every 40 items, pick at random whether the next stretch has idle cycles
			if (n % 40 == 0)
				idle_on = ($urandom_range(0, 3) != 0);
			send_request(random_request());
		end
		idle_on = 1'b1;
	endtask

	task automatic finish_run();
		req_valid <= 1'b0;
		while (pending_indexes.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("vertex_dedup_table_core_tb passed");
		else
			$display("vertex_dedup_table_core_tb failed");
		$finish;
	endtask

	initial begin
		arst_n = 1'b0;
		req_valid = 1'b0;
		req_data = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_lookup_basics();
		test_full_table();
		test_random_meshes();
		finish_run();
	end

endmodule
